FILE: hw/rtl/rmse_pkg.sv
// rmse_pkg: field widths and fixed constants of the running mean and standard error block
// no dependencies; used by the channel interfaces and the top level

package rmse_pkg;

	localparam int SMP_W  = 24;
	localparam int MEAN_W = 24;
	localparam int SE_W   = 23;
	localparam int SQ_W   = 47;
	localparam int ROOT_W = 24;
	localparam int QUO_W  = 2 * ROOT_W;

	localparam logic [SE_W-1:0] SE_MAX = {SE_W{1'b1}};

endpackage

FILE: hw/rtl/rmse_if.sv
// rmse_in_if, rmse_out_if: valid/ready channels of the running mean and standard error block
// depends on rmse_pkg for the field widths

interface rmse_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [rmse_pkg::SMP_W-1:0] sample;
	logic                              restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmse_out_if #(
	parameter int MAX_BLOCKS = 1024
);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	logic                               valid;
	logic                               ready;
	logic signed [rmse_pkg::MEAN_W-1:0] running_mean;
	logic        [rmse_pkg::SE_W-1:0]   std_error;
	logic        [CW-1:0]               block_count;
	logic                               full_res;

	modport source (output valid, output running_mean, output std_error, output block_count,
		output full_res, input ready);
	modport sink   (input valid, input running_mean, input std_error, input block_count,
		input full_res, output ready);
endinterface

FILE: hw/rtl/rmse_mul.sv
// rmse_mul: unsigned shift-add multiplier, one multiplier bit per cycle
// no dependencies

module rmse_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] p
);

	localparam int CNTW = $clog2(BW + 1);

	logic [AW+BW-1:0] p_q;
	logic [AW-1:0]    a_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic [AW:0]      sum;

	assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(BW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNTW'(1));
			cnt_q  <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{AW{1'b0}}, b};
			a_q <= a;
		end else if (busy_q) begin
			p_q <= {sum, p_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign p    = p_q;

endmodule

FILE: hw/rtl/rmse_div.sv
// rmse_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies

module rmse_div #(
	parameter int NW = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   q_q;
	logic [DW-1:0]   r_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW:0]     trial;
	logic            ge;
	logic [DW:0]     rnext;

	assign trial = {r_q, q_q[NW-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign rnext = ge ? (trial - {1'b0, den_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNTW'(1));
			cnt_q  <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q <= {q_q[NW-2:0], ge};
			r_q <= rnext[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = q_q;

endmodule

FILE: hw/rtl/rmse_sqrt.sv
// rmse_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// no dependencies

module rmse_sqrt #(
	parameter int RW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] rad,
	output logic            busy,
	output logic [RW-1:0]   root
);

	localparam int CNTW = $clog2(RW + 1);

	logic [2*RW-1:0] x_q;
	logic [RW-1:0]   root_q;
	logic [RW:0]     rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [RW+1:0]   cur;
	logic [RW+1:0]   trial;
	logic            ge;
	logic [RW+1:0]   rnext;

	assign cur   = {rem_q[RW-1:0], x_q[2*RW-1:2*RW-2]};
	assign trial = {root_q, 2'b01};
	assign ge    = (cur >= trial);
	assign rnext = ge ? (cur - trial) : cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(RW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNTW'(1));
			cnt_q  <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[2*RW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], ge};
			rem_q  <= rnext[RW:0];
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

FILE: hw/rtl/running_mean_standard_error.sv
// running_mean_standard_error: running mean and standard error of a series of block estimates
// depends on rmse_pkg, rmse_if, rmse_mul, rmse_div and rmse_sqrt
//
// usage
//   samples: one block estimate (signed, 16 fraction bits) and a restart flag per transfer;
//     restart clears the series and the sample becomes its first
//   results: one transfer per sample with the running mean, the standard error of the mean,
//     the sample count and a flag for a sample dropped because the series is full
//   one item is worked on at a time; samples.ready is high only while the block is idle
//   an item is worked on from its transfer until ready returns, and no sample is taken
//     meanwhile; the result shows on results in the same cycle that ready returns
//   work time is set by the bit-serial multipliers (sample squared, then sum squared, SW bits
//     each; then n*(n-1)*n, CW bits), the bit-serial variance divider (NUMW bits) and the root
//   reset clears the count and both sums, so the first sample starts a series
//   a stalled receiver holds its result in the output register; the next sample is still
//     taken and worked on, and its result waits until the register is free

module running_mean_standard_error #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	rmse_in_if.sink           samples,
	rmse_out_if.source        results
);

	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int LGM   = $clog2(MAX_BLOCKS);
	localparam int SW    = rmse_pkg::SMP_W + LGM;
	localparam int QW    = rmse_pkg::SQ_W + LGM;
	localparam int AWN   = CW + QW;
	localparam int BWS   = 2 * SW;
	localparam int NUMW  = (AWN > BWS) ? AWN : BWS;
	localparam int DW    = 3 * CW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_GO2  = 4'd2;
	localparam logic [3:0] ST_RUN2 = 4'd3;
	localparam logic [3:0] ST_GO3  = 4'd4;
	localparam logic [3:0] ST_RUN3 = 4'd5;
	localparam logic [3:0] ST_GO4  = 4'd6;
	localparam logic [3:0] ST_RUN4 = 4'd7;
	localparam logic [3:0] ST_GO5  = 4'd8;
	localparam logic [3:0] ST_RUN5 = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]        state_q;
	logic [CW-1:0]     n_q;
	logic signed [SW-1:0] s_q;
	logic [QW-1:0]     q_q;
	logic              full_q;
	logic [NUMW-1:0]   num_q;

	logic                                 out_valid_q;
	logic signed [rmse_pkg::MEAN_W-1:0]   mean_q;
	logic        [rmse_pkg::SE_W-1:0]     se_q;
	logic        [CW-1:0]                 count_q;
	logic                                 full_res_q;

	logic                         accept_in;
	logic [rmse_pkg::SMP_W-1:0]   v_abs;
	logic [CW-1:0]                n_eff;
	logic signed [SW-1:0]         s_eff;
	logic                         full_now;
	logic [SW-1:0]                s_abs;

	logic             start_a, busy_a;
	logic [QW-1:0]    opa_a;
	logic [AWN-1:0]   p_a;
	logic             start_b, busy_b;
	logic [SW-1:0]    opa_b;
	logic [BWS-1:0]   p_b;
	logic             start_c, busy_c;
	logic [2*CW-1:0]  p_c;
	logic             start_m, busy_m;
	logic [SW-1:0]    quo_m;
	logic             start_v, busy_v;
	logic [NUMW-1:0]  quo_v;
	logic             start_r, busy_r;
	logic [rmse_pkg::ROOT_W-1:0] root_r;

	logic [NUMW:0]                     diff;
	logic [rmse_pkg::MEAN_W-1:0]       mean_mag;
	logic signed [rmse_pkg::MEAN_W-1:0] mean_val;
	logic [rmse_pkg::SE_W-1:0]         se_val;
	logic                              load_out;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept_in     = samples.valid && samples.ready;

	assign v_abs    = samples.sample[rmse_pkg::SMP_W-1] ? (-samples.sample) : samples.sample;
	assign n_eff    = samples.restart ? '0 : n_q;
	assign s_eff    = samples.restart ? '0 : s_q;
	assign full_now = (n_eff >= CW'(MAX_BLOCKS));
	assign s_abs    = s_q[SW-1] ? (-s_q) : s_q;

	// shared multiplier a: n*Q, then n*(n-1)*n
	assign start_a = (state_q == ST_GO2) || (state_q == ST_GO3);
	assign opa_a   = (state_q == ST_GO3) ? QW'(p_c) : q_q;

	// shared multiplier b: sample squared, then sum squared
	assign start_b = accept_in || (state_q == ST_GO2);
	assign opa_b   = (state_q == ST_IDLE) ? SW'(v_abs) : s_abs;

	assign start_c = (state_q == ST_GO2);
	assign start_m = (state_q == ST_GO2);
	assign start_v = (state_q == ST_GO4);
	assign start_r = (state_q == ST_GO5);

	rmse_mul #(.AW(QW), .BW(CW)) u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_a),
		.a      (opa_a),
		.b      (n_q),
		.busy   (busy_a),
		.p      (p_a)
	);

	rmse_mul #(.AW(SW), .BW(SW)) u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_b),
		.a      (opa_b),
		.b      (opa_b),
		.busy   (busy_b),
		.p      (p_b)
	);

	rmse_mul #(.AW(CW), .BW(CW)) u_mul_c (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_c),
		.a      (n_q),
		.b      (n_q - CW'(1)),
		.busy   (busy_c),
		.p      (p_c)
	);

	rmse_div #(.NW(SW), .DW(CW)) u_div_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_m),
		.num    (s_abs),
		.den    (n_q),
		.busy   (busy_m),
		.quo    (quo_m)
	);

	rmse_div #(.NW(NUMW), .DW(DW)) u_div_var (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_v),
		.num    (num_q),
		.den    (p_a[DW-1:0]),
		.busy   (busy_v),
		.quo    (quo_v)
	);

	rmse_sqrt #(.RW(rmse_pkg::ROOT_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_r),
		.rad    (quo_v[rmse_pkg::QUO_W-1:0]),
		.busy   (busy_r),
		.root   (root_r)
	);

	// n*Q - S*S, clamped at zero
	assign diff = {1'b0, NUMW'(p_a)} - {1'b0, NUMW'(p_b)};

	assign mean_mag = quo_m[rmse_pkg::MEAN_W-1:0];
	assign mean_val = s_q[SW-1] ? (-mean_mag) : mean_mag;
	assign se_val   = (n_q < CW'(2)) ? '0 :
		(root_r[rmse_pkg::ROOT_W-1] ? rmse_pkg::SE_MAX : root_r[rmse_pkg::SE_W-1:0]);

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			s_q     <= '0;
			q_q     <= '0;
			full_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						full_q <= full_now;
						if (!full_now) begin
							n_q <= n_eff + CW'(1);
							s_q <= s_eff + SW'(samples.sample);
						end else begin
							n_q <= n_eff;
							s_q <= s_eff;
						end
						if (samples.restart) begin
							q_q <= '0;
						end
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (!busy_b) begin
						if (!full_q) begin
							q_q <= q_q + QW'(p_b[rmse_pkg::SQ_W-1:0]);
						end
						state_q <= ST_GO2;
					end
				end
				ST_GO2: state_q <= ST_RUN2;
				ST_RUN2: begin
					if (!(busy_a || busy_b || busy_c || busy_m)) begin
						state_q <= ST_GO3;
					end
				end
				ST_GO3: state_q <= ST_RUN3;
				ST_RUN3: begin
					if (!busy_a) begin
						state_q <= ST_GO4;
					end
				end
				ST_GO4: state_q <= ST_RUN4;
				ST_RUN4: begin
					if (!busy_v) begin
						state_q <= ST_GO5;
					end
				end
				ST_GO5: state_q <= ST_RUN5;
				ST_RUN5: begin
					if (!busy_r) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GO3) begin
			num_q <= diff[NUMW] ? '0 : diff[NUMW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_q     <= mean_val;
			se_q       <= se_val;
			count_q    <= n_q;
			full_res_q <= full_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.running_mean = mean_q;
	assign results.std_error    = se_q;
	assign results.block_count  = count_q;
	assign results.full_res     = full_res_q;

endmodule

FILE: hw/rtl/rmse_checker.sv
// rmse_checker: port-level assertions for running_mean_standard_error, bound to the top level
// depends on rmse_pkg for the field widths

module rmse_checker #(
	parameter int MAX_BLOCKS = 1024,
	localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [CW-1:0]             block_count,
	input logic [rmse_pkg::SE_W-1:0] std_error,
	input logic                      full_res
);

	// a result waits until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// one item at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while an item is in work");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> block_count == CW'(MAX_BLOCKS))
		else $error("full flag with a series that is not full");

	a_first_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_count == CW'(1) |-> std_error == '0)
		else $error("nonzero error for the first block");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_count != '0 && block_count <= CW'(MAX_BLOCKS))
		else $error("block count out of range");

endmodule

bind running_mean_standard_error rmse_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_rmse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.block_count (results.block_count),
	.std_error   (results.std_error),
	.full_res    (results.full_res)
);

FILE: tb/sv/rmse_series_checker.sv
`timescale 1ns / 100ps
// rmse_series_checker: watches the sample and result channels, predicts every result and compares
// depends on rmse_pkg and the channel interfaces of rmse_if

module rmse_series_checker #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	rmse_in_if   smp_ch,
	rmse_out_if  res_ch,
	output int   err_count,
	output int   outstanding
);
	import rmse_pkg::*;

	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W = SMP_W + CW;
	localparam int SQS_W = 2 * SMP_W + CW;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean;
		logic        [SE_W-1:0]   se;
		logic        [CW-1:0]     count;
		logic                     full;
	} series_stats_t;

	series_stats_t           expected_stats[$];
	logic        [CW-1:0]    n_blocks;
	logic signed [SUM_W-1:0] sum_est;
	logic        [SQS_W-1:0] sum_sq;

	initial begin
		err_count   = 0;
		outstanding = 0;
		n_blocks    = '0;
		sum_est     = '0;
		sum_sq      = '0;
	end

	task automatic report_mismatch(input string what, input logic signed [63:0] got,
		input logic signed [63:0] want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// floor(sqrt(floor((n*q - s*s) / (n*n*(n-1))))), saturated
	function automatic logic [SE_W-1:0] std_error_of(input logic [CW-1:0] n,
		input logic signed [SUM_W-1:0] s, input logic [SQS_W-1:0] q);
		logic signed [127:0] n_wide;
		logic signed [127:0] q_wide;
		logic signed [127:0] s_wide;
		logic signed [127:0] spread;
		logic        [127:0] var_q;
		logic        [127:0] root;
		logic        [127:0] trial;
		if (n < 2)
			return '0;
		n_wide = n;
		q_wide = q;
		s_wide = s;
		spread = n_wide * q_wide - s_wide * s_wide;
		if (spread <= 0)
			return '0;
		var_q = spread / (n_wide * n_wide * (n_wide - 1));
		root  = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= var_q)
				root = trial;
		end
		return (root > SE_MAX) ? SE_MAX : root[SE_W-1:0];
	endfunction

	function automatic series_stats_t advance_series(input logic signed [SMP_W-1:0] smp,
		input logic restart);
		series_stats_t             r;
		logic signed [2*SMP_W-1:0] sq;
		longint                    mean_l;
		if (restart) begin
			n_blocks = '0;
			sum_est  = '0;
			sum_sq   = '0;
		end
		r.full = (n_blocks >= MAX_BLOCKS);
		if (!r.full) begin
			sq       = smp * smp;
			n_blocks = n_blocks + 1'b1;
			sum_est  = sum_est + smp;
			sum_sq   = sum_sq + sq;
		end
		mean_l  = longint'(sum_est) / longint'(n_blocks);
		r.mean  = mean_l[MEAN_W-1:0];
		r.se    = std_error_of(n_blocks, sum_est, sum_sq);
		r.count = n_blocks;
		return r;
	endfunction

	always @(posedge clk) begin
		series_stats_t got;
		series_stats_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.mean  = res_ch.running_mean;
				got.se    = res_ch.std_error;
				got.count = res_ch.block_count;
				got.full  = res_ch.full_res;
				if (expected_stats.size() == 0) begin
					report_mismatch("unexpected result, running_mean", got.mean, 0);
				end else begin
					want = expected_stats.pop_front();
					if (got.mean !== want.mean)
						report_mismatch("running_mean", got.mean, want.mean);
					if (got.se !== want.se)
						report_mismatch("std_error", got.se, want.se);
					if (got.count !== want.count)
						report_mismatch("block_count", got.count, want.count);
					if (got.full !== want.full)
						report_mismatch("full_res", got.full, want.full);
				end
			end
			if (smp_ch.valid && smp_ch.ready)
				expected_stats.push_back(advance_series(smp_ch.sample, smp_ch.restart));
			outstanding <= expected_stats.size();
		end
	end

endmodule

FILE: tb/sv/tb_running_mean_standard_error.sv
`timescale 1ns / 100ps
// tb_running_mean_standard_error: stimulus and verdict for the running mean and standard error block
// depends on rmse_pkg, rmse_if, the block's rtl and rmse_series_checker

module tb_running_mean_standard_error;
	import rmse_pkg::*;

	localparam int MAX_BLOCKS   = 1024;
	localparam int DRAIN_CYCLES = 200;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	logic clk;
	logic arst_n;
	bit   steady = 1'b0;
	int   err_count;
	int   outstanding;

	rmse_in_if                             smp_ch ();
	rmse_out_if #(.MAX_BLOCKS(MAX_BLOCKS)) res_ch ();

	running_mean_standard_error #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.results (res_ch)
	);

	rmse_series_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp_ch      (smp_ch),
		.res_ch      (res_ch),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("DONE: errors detected");
		$finish;
	end

	// hold valid high across back-to-back transfers when steady; otherwise a random gap drops it first
	task automatic send_estimate(input logic signed [SMP_W-1:0] smp, input logic restart);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid   <= 1'b1;
		smp_ch.sample  <= smp;
		smp_ch.restart <= restart;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
	endtask

	function automatic logic signed [SMP_W-1:0] draw_estimate(
		input logic signed [SMP_W-1:0] centre);
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return SMP_MAX - r[1:0];
			1: return SMP_MIN + r[1:0];
			2, 3: return r[SMP_W-1:0];
			4: return $signed(r[11:0]);
			default: return centre + $signed(r[15:0]);
		endcase
	endfunction

	task automatic send_series(input int len, input bit open_restart,
		input logic signed [SMP_W-1:0] centre);
		for (int i = 0; i < len; i++)
			send_estimate(draw_estimate(centre), open_restart && (i == 0));
	endtask

	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] r;
		smp_ch.valid   <= 1'b0;
		smp_ch.sample  <= '0;
		smp_ch.restart <= 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// series started without restart after reset
		send_estimate('0, 1'b0);
		send_estimate(SMP_MAX, 1'b0);
		send_estimate(SMP_MIN, 1'b0);
		send_estimate(24'sd1, 1'b0);
		// widest spread, error reaches its largest value
		send_estimate(SMP_MAX, 1'b1);
		send_estimate(SMP_MIN, 1'b0);
		// constant series, zero spread
		send_estimate(SMP_MIN, 1'b1);
		send_estimate(SMP_MIN, 1'b0);
		send_estimate(SMP_MIN, 1'b0);
		// negative mean truncated toward zero
		send_estimate(-24'sd1, 1'b1);
		send_estimate(-24'sd2, 1'b0);
		send_estimate(24'sd1, 1'b0);
		send_estimate(24'sh00_8000, 1'b1);
		send_estimate(24'sh01_0000, 1'b0);
		send_estimate(24'sh01_8000, 1'b0);
		send_estimate(-24'sh01_0000, 1'b0);
		send_estimate('0, 1'b1);
		send_estimate('0, 1'b1);

		for (int k = 0; k < 15; k++) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom;
			send_series($urandom_range(1, 5), $urandom_range(0, 7) != 0, r[SMP_W-1:0]);
		end

		// one long series that runs past the block limit
		r = $urandom;
		for (int c = 0; c < 16; c++) begin
			steady = ($urandom_range(0, 3) == 0);
			send_series(66, c == 0, r[SMP_W-1:0]);
		end

		// restart out of a full series
		steady = 1'b0;
		send_estimate(draw_estimate(r[SMP_W-1:0]), 1'b1);
		for (int k = 0; k < 15; k++) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom;
			send_series($urandom_range(1, 5), $urandom_range(0, 7) != 0, r[SMP_W-1:0]);
		end

		smp_ch.valid <= 1'b0;
		steady = 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
